/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hw/rtl/iaie_pkg.sv */
package iaie_pkg;

  localparam int unsigned XLEN        = 32;
  localparam int unsigned REG_IDX_W   = 5;
  localparam int unsigned RF_DEPTH    = 32;
  localparam int unsigned IMM_W       = 16;

  localparam int unsigned IN_TDATA_W  = 32;
  // wrote(1) + dest_reg(5) + write_value(32) = 38, padded to whole bytes
  localparam int unsigned OUT_FIELD_W = 1 + REG_IDX_W + XLEN;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Top three opcode bits of the immediate ALU group
  localparam logic [2:0] GROUP_IMM = 3'b001;

  typedef enum logic [2:0] {
    OP_ADDI  = 3'b000,
    OP_ADDIU = 3'b001,
    OP_SLTI  = 3'b010,
    OP_SLTIU = 3'b011,
    OP_ANDI  = 3'b100,
    OP_ORI   = 3'b101,
    OP_XORI  = 3'b110,
    OP_LUI   = 3'b111
  } op_e;

  // Decoded instruction as held in the queue
  typedef struct packed {
    logic                 not_impl;
    op_e                  op;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [IMM_W-1:0]     imm;
  } dec_t;

endpackage

/* hw/rtl/immediate_alu_instruction_executor_core.sv */
// Immediate ALU executor: takes one 32-bit instruction word per cycle on the
// slave stream while the queue has room, and returns one result word per
// instruction on the master stream, in order. Words whose top opcode bits are
// 001 (ADDI, ADDIU, SLTI, SLTIU, ANDI, ORI, XORI, LUI) read rs from a 32-entry
// register file, compute, and write rt; r0 stays zero, ADDI wraps without a
// trap. Any other opcode is flagged not implemented (tuser high) and writes
// nothing. The register file is all zero after reset. Sustained rate is one
// word per cycle while the master side takes every result word. An accepted
// word is written into the queue; the back stage, where register read and
// ALU are combinational, pops it when the output register is empty or being
// taken, writes rt back and loads the result word into the output register.
// Back-to-back dependent instructions need no forwarding. A two-entry queue
// between decode and execute, plus the output register, lets input and
// output stall independently; tready drops only once the queue is full behind
// a stalled output.
module immediate_alu_instruction_executor_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] instr_word
  input  logic [iaie_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] wrote, [5:1] dest_reg, [37:6] write_value, [39:38] zero
  output logic [iaie_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] status: 0 executed, 1 not implemented
  output logic                             m_axis_tuser_o
);

  logic           push;
  iaie_pkg::dec_t push_entry;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  iaie_pkg::dec_t q_entry;

  // Decode: classify opcode group, split register and immediate fields
  iaie_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  // Decoupling queue
  iaie_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (q_entry)
  );

  // Execute and writeback, result held in the output register
  iaie_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* hw/rtl/iaie_front.sv */
// Front end: takes instruction words and decodes them into queue entries.
module iaie_front (
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [iaie_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output iaie_pkg::dec_t                       push_entry_o
);

  logic [2:0] group;

  assign group           = s_axis_tdata_i[31:29];
  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    push_entry_o.not_impl = (group != iaie_pkg::GROUP_IMM);
    push_entry_o.op       = iaie_pkg::op_e'(s_axis_tdata_i[28:26]);
    push_entry_o.rs       = s_axis_tdata_i[25:21];
    push_entry_o.rt       = s_axis_tdata_i[20:16];
    push_entry_o.imm      = s_axis_tdata_i[15:0];
  end

endmodule

/* hw/rtl/iaie_queue.sv */
`include "assert_macros.svh"

// Small FIFO of decoded words between front and back.
module iaie_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  iaie_pkg::dec_t push_entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output iaie_pkg::dec_t pop_entry_o
);

  iaie_pkg::dec_t                  mem_q [iaie_pkg::QUEUE_DEPTH];
  logic [iaie_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [iaie_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [iaie_pkg::QCNT_W-1:0]     count_q, count_d;

  localparam logic [iaie_pkg::QPTR_W-1:0] PtrLast =
    iaie_pkg::QPTR_W'(iaie_pkg::QUEUE_DEPTH - 1);
  localparam logic [iaie_pkg::QCNT_W-1:0] CntFull =
    iaie_pkg::QCNT_W'(iaie_pkg::QUEUE_DEPTH);

  assign full_o      = (count_q == CntFull);
  assign valid_o     = (count_q != '0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, pop_i && !valid_o)

endmodule

/* hw/rtl/iaie_back.sv */
`include "assert_macros.svh"

// Back end: register file read, ALU, writeback and output register.
module iaie_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  iaie_pkg::dec_t                       q_entry_i,
  output logic                                 pop_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [iaie_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                 m_axis_tuser_o
);

  logic [iaie_pkg::XLEN-1:0]      rf_q [iaie_pkg::RF_DEPTH];
  logic [iaie_pkg::XLEN-1:0]      src_a;
  logic [iaie_pkg::XLEN-1:0]      sext;
  logic [iaie_pkg::XLEN-1:0]      zext;
  logic [iaie_pkg::XLEN-1:0]      alu_res;
  logic                           wr_en;

  logic                           out_vld_q, out_vld_d;
  logic                           status_q, status_d;
  logic                           wrote_q, wrote_d;
  logic [iaie_pkg::REG_IDX_W-1:0] dest_q, dest_d;
  logic [iaie_pkg::XLEN-1:0]      value_q, value_d;

  assign pop_o = q_valid_i && (!out_vld_q || m_axis_tready_i);

  assign src_a = rf_q[q_entry_i.rs];
  assign sext  = {{(iaie_pkg::XLEN - iaie_pkg::IMM_W){q_entry_i.imm[iaie_pkg::IMM_W-1]}},
                  q_entry_i.imm};
  assign zext  = {{(iaie_pkg::XLEN - iaie_pkg::IMM_W){1'b0}}, q_entry_i.imm};

  always_comb begin
    case (q_entry_i.op)
      iaie_pkg::OP_ADDI,
      iaie_pkg::OP_ADDIU: alu_res = src_a + sext;  // wraps, no overflow trap
      iaie_pkg::OP_SLTI:  alu_res = {{(iaie_pkg::XLEN-1){1'b0}},
                                     ($signed(src_a) < $signed(sext))};
      iaie_pkg::OP_SLTIU: alu_res = {{(iaie_pkg::XLEN-1){1'b0}}, (src_a < sext)};
      iaie_pkg::OP_ANDI:  alu_res = src_a & zext;
      iaie_pkg::OP_ORI:   alu_res = src_a | zext;
      iaie_pkg::OP_XORI:  alu_res = src_a ^ zext;
      iaie_pkg::OP_LUI:   alu_res = {q_entry_i.imm,
                                     {(iaie_pkg::XLEN - iaie_pkg::IMM_W){1'b0}}};
      default:            alu_res = '0;
    endcase
  end

  // r0 is never written and so reads zero for ever
  assign wr_en = pop_o && !q_entry_i.not_impl && (q_entry_i.rt != '0);

  always_comb begin
    out_vld_d = out_vld_q;
    status_d  = status_q;
    wrote_d   = wrote_q;
    dest_d    = dest_q;
    value_d   = value_q;
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (pop_o) begin
      out_vld_d = 1'b1;
      status_d  = q_entry_i.not_impl;
      wrote_d   = wr_en;
      dest_d    = q_entry_i.not_impl ? '0 : q_entry_i.rt;
      value_d   = wr_en ? alu_res : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    wrote_q  <= wrote_d;
    dest_q   <= dest_d;
    value_q  <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iaie_pkg::RF_DEPTH; i++) begin
        rf_q[i] <= '0;
      end
    end else if (wr_en) begin
      rf_q[q_entry_i.rt] <= alu_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {{iaie_pkg::OUT_PAD_W{1'b0}}, value_q, dest_q, wrote_q};

  `ASSERT_NEVER(a_r0_zero, clk_i, rst_ni, rf_q[0] != '0)
  `ASSERT_PROP(a_wb_matches_out, clk_i, rst_ni,
    pop_o |=> (wrote_q == 1'b0) || (rf_q[dest_q] == value_q))
  `ASSERT_NEVER(a_no_write_on_unimpl, clk_i, rst_ni,
    out_vld_q && status_q && (wrote_q || (value_q != '0)))

endmodule

/* tb/sv/tb_immediate_alu_instruction_executor_core.sv */
// Stream-level bench for the immediate ALU executor. Instruction words go in
// on the slave side; every accepted word is run through a shadow register
// file here and the expected result word is queued. Result words coming out
// of the master side are popped and compared field by field.
module tb_immediate_alu_instruction_executor_core;

  timeunit 1ns;
  timeprecision 1ps;

  // status codes carried on m_axis_tuser
  localparam logic ST_EXEC   = 1'b0;
  localparam logic ST_NOIMPL = 1'b1;

  localparam int  WORDS_PER_PHASE = 400;
  localparam int  RX_HOLD_CYCLES  = 40;
  localparam int  MAX_ERR_LINES   = 40;
  localparam real TIMEOUT_NS      = 2_000_000.0;

  // Expected content of one result word
  typedef struct packed {
    logic                           status;
    logic                           wrote;
    logic [iaie_pkg::REG_IDX_W-1:0] dest;
    logic [iaie_pkg::XLEN-1:0]      value;
  } retire_t;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic [iaie_pkg::IN_TDATA_W-1:0] word;
    bit                              typed;
    retire_t                         res;
  } dir_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  // [31:0] instr_word
  logic [iaie_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  // [0] wrote, [5:1] dest_reg, [37:6] write_value, [39:38] zero
  logic [iaie_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  // [0] status
  logic                             m_axis_tuser_o;

  logic [iaie_pkg::XLEN-1:0] shadow_rf [iaie_pkg::RF_DEPTH];
  retire_t                   retire_q [$];
  dir_row_t                  dir_rows [];

  int tx_idle_pct = 12;
  int rx_idle_pct = 47;
  bit hold_rx     = 1'b0;
  int err_cnt     = 0;

  immediate_alu_instruction_executor_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Prints one line (up to a cap) and counts
  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_ERR_LINES) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [iaie_pkg::IN_TDATA_W-1:0] imm_word(input iaie_pkg::op_e op,
                                                               input logic [4:0] rs,
                                                               input logic [4:0] rt,
                                                               input logic [15:0] imm);
    return {iaie_pkg::GROUP_IMM, op, rs, rt, imm};
  endfunction

  // Executes one word against the shadow register file and returns the
  // result word it should produce. r0 is never written.
  function automatic retire_t retire_model(input logic [iaie_pkg::IN_TDATA_W-1:0] w);
    retire_t                   r;
    iaie_pkg::op_e             op;
    logic [4:0]                rs;
    logic [4:0]                rt;
    logic [15:0]               imm;
    logic [iaie_pkg::XLEN-1:0] a;
    logic [iaie_pkg::XLEN-1:0] sext;
    logic [iaie_pkg::XLEN-1:0] zext;
    logic [iaie_pkg::XLEN-1:0] v;
    r    = '0;
    op   = iaie_pkg::op_e'(w[28:26]);
    rs   = w[25:21];
    rt   = w[20:16];
    imm  = w[15:0];
    a    = shadow_rf[rs];
    sext = {{16{imm[15]}}, imm};
    zext = {16'h0000, imm};
    if (w[31:29] != iaie_pkg::GROUP_IMM) begin
      r.status = ST_NOIMPL;
      return r;
    end
    case (op)
      iaie_pkg::OP_ADDI, iaie_pkg::OP_ADDIU: v = a + sext;   // ADDI wraps, no trap
      iaie_pkg::OP_SLTI:  v = ($signed(a) < $signed(sext)) ? 32'd1 : 32'd0;
      iaie_pkg::OP_SLTIU: v = (a < sext) ? 32'd1 : 32'd0;
      iaie_pkg::OP_ANDI:  v = a & zext;
      iaie_pkg::OP_ORI:   v = a | zext;
      iaie_pkg::OP_XORI:  v = a ^ zext;
      default:            v = {imm, 16'h0000};
    endcase
    r.status = ST_EXEC;
    r.dest   = rt;
    if (rt != '0) begin
      shadow_rf[rt] = v;
      r.wrote = 1'b1;
      r.value = v;
    end
    return r;
  endfunction

  // Mostly well-formed immediate instructions over a handful of registers so
  // results feed back into later sources; the rest is arbitrary words.
  function automatic logic [iaie_pkg::IN_TDATA_W-1:0] rand_word();
    iaie_pkg::op_e op;
    logic [4:0]    rs;
    logic [4:0]    rt;
    logic [15:0]   imm;
    if ($urandom_range(99) >= 80) begin
      return $urandom();
    end
    op = iaie_pkg::op_e'($urandom_range(7));
    rs = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    rt = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    case ($urandom_range(7))
      0:       imm = 16'h0000;
      1:       imm = 16'hffff;
      2:       imm = 16'h8000;
      3:       imm = 16'h7fff;
      default: imm = 16'($urandom());
    endcase
    return imm_word(op, rs, rt, imm);
  endfunction

  // Offers one word, with random idle cycles in front of it; valid is only
  // dropped while idling or by retire_wait, never in the step it is raised.
  task automatic send_word(input logic [iaie_pkg::IN_TDATA_W-1:0] w, input bit typed,
                           input retire_t typed_res);
    retire_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // accepted: shadow state always advances, typed rows keep their own answer
    r = retire_model(w);
    retire_q.push_back(typed ? typed_res : r);
  endtask

  // Sender pauses until every queued result has come back
  task automatic retire_wait();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, or a solid hold-off while hold_rx is set
  always @(negedge clk_i) begin
    m_axis_tready_i <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    retire_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (retire_q.size() == 0) begin
        flag_error($sformatf("unexpected result word %h", m_axis_tdata_o));
      end else begin
        want = retire_q.pop_front();
        if (m_axis_tuser_o !== want.status)
          flag_error($sformatf("status %b, want %b", m_axis_tuser_o, want.status));
        if (m_axis_tdata_o[0] !== want.wrote)
          flag_error($sformatf("wrote %b, want %b", m_axis_tdata_o[0], want.wrote));
        if (m_axis_tdata_o[5:1] !== want.dest)
          flag_error($sformatf("dest %0d, want %0d", m_axis_tdata_o[5:1], want.dest));
        if (m_axis_tdata_o[37:6] !== want.value)
          flag_error($sformatf("value %h, want %h", m_axis_tdata_o[37:6], want.value));
        if (m_axis_tdata_o[iaie_pkg::OUT_TDATA_W-1:iaie_pkg::OUT_FIELD_W] !== '0)
          flag_error($sformatf("pad bits %b not zero",
                     m_axis_tdata_o[iaie_pkg::OUT_TDATA_W-1:iaie_pkg::OUT_FIELD_W]));
      end
    end
  end

  initial begin
    foreach (shadow_rf[i]) shadow_rf[i] = '0;

    // Register values in the comments follow the rows in order
    dir_rows = '{
      // from r0 after reset: both immediate extremes
      '{imm_word(iaie_pkg::OP_ADDI,  0,  1, 16'h7fff), 1'b1,
        '{ST_EXEC, 1'b1, 5'd1, 32'h0000_7fff}},
      '{imm_word(iaie_pkg::OP_ADDIU, 0,  2, 16'h8000), 1'b1,
        '{ST_EXEC, 1'b1, 5'd2, 32'hffff_8000}},
      '{imm_word(iaie_pkg::OP_LUI,   0,  3, 16'hffff), 1'b1,
        '{ST_EXEC, 1'b1, 5'd3, 32'hffff_0000}},
      '{imm_word(iaie_pkg::OP_ORI,   3,  3, 16'hffff), 1'b0, '0},  // r3 = all ones
      '{imm_word(iaie_pkg::OP_ADDIU, 3,  4, 16'h0001), 1'b0, '0},  // wraps to zero
      '{imm_word(iaie_pkg::OP_LUI,   0,  5, 16'h7fff), 1'b1,
        '{ST_EXEC, 1'b1, 5'd5, 32'h7fff_0000}},
      '{imm_word(iaie_pkg::OP_ORI,   5,  5, 16'hffff), 1'b0, '0},  // r5 = max positive
      '{imm_word(iaie_pkg::OP_ADDI,  5,  6, 16'h0001), 1'b0, '0},  // signed overflow
      '{imm_word(iaie_pkg::OP_ADDI,  6,  6, 16'hffff), 1'b0, '0},  // and back down
      '{imm_word(iaie_pkg::OP_SLTI,  3,  7, 16'h0000), 1'b0, '0},  // -1 < 0
      '{imm_word(iaie_pkg::OP_SLTI,  1,  8, 16'h8000), 1'b0, '0},  // 0x7fff < -32768
      '{imm_word(iaie_pkg::OP_SLTIU, 3,  9, 16'hffff), 1'b0, '0},  // equal after sext
      '{imm_word(iaie_pkg::OP_SLTIU, 1, 10, 16'h8000), 1'b0, '0},  // imm extends huge
      '{imm_word(iaie_pkg::OP_SLTIU, 0, 11, 16'h0000), 1'b0, '0},
      '{imm_word(iaie_pkg::OP_ANDI,  3, 12, 16'h8001), 1'b0, '0},  // zero-extended mask
      '{imm_word(iaie_pkg::OP_XORI,  2, 13, 16'hffff), 1'b0, '0},
      // writes to r0 are dropped, and r0 still reads zero afterwards
      '{imm_word(iaie_pkg::OP_ADDI,  3,  0, 16'h0005), 1'b1,
        '{ST_EXEC, 1'b0, 5'd0, 32'h0}},
      '{imm_word(iaie_pkg::OP_ORI,   0, 14, 16'h0000), 1'b0, '0},
      '{imm_word(iaie_pkg::OP_LUI,   0, 31, 16'ha5a5), 1'b1,
        '{ST_EXEC, 1'b1, 5'd31, 32'ha5a5_0000}},
      '{imm_word(iaie_pkg::OP_XORI, 31, 31, 16'hffff), 1'b0, '0},
      // other opcode groups: not implemented, nothing written
      '{32'h0000_0000, 1'b1, '{ST_NOIMPL, 1'b0, 5'd0, 32'h0}},
      '{32'hffff_ffff, 1'b1, '{ST_NOIMPL, 1'b0, 5'd0, 32'h0}},
      '{32'h5fff_ffff, 1'b1, '{ST_NOIMPL, 1'b0, 5'd0, 32'h0}},
      '{32'h1fff_ffff, 1'b1, '{ST_NOIMPL, 1'b0, 5'd0, 32'h0}}
    };

    // reset held, then released on a falling edge, away from the rising edge
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
    retire_wait();

    // random words: sender idles lightly, then receiver does, then nobody
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 47 : 0;
      rx_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 12 : 0;
      if (ph == 2) begin
        // long receiver hold-off while words keep coming: fills the queue
        fork
          begin
            @(posedge clk_i);
            hold_rx = 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk_i);
            hold_rx = 1'b0;
          end
        join_none
      end
      repeat (WORDS_PER_PHASE) send_word(rand_word(), 1'b0, '0);
      retire_wait();
    end

    // then catch any stray result word before the final check
    repeat (6) @(posedge clk_i);
    if (retire_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", retire_q.size()));

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/iaie_pkg.sv
hw/rtl/iaie_front.sv
hw/rtl/iaie_queue.sv
hw/rtl/iaie_back.sv
hw/rtl/immediate_alu_instruction_executor_core.sv
tb/sv/tb_immediate_alu_instruction_executor_core.sv
